// File: rtl/tmhq_pkg.sv
// Shared types and constants for the ternary min-heap queue.
// Request/status codes, sequencer states and compare-unit operations.
// No dependencies.
`default_nettype none

package tmhq_pkg;

  localparam int KEY_W    = 32;
  localparam int CNT_W    = 11;
  // (x * DIV3_MUL) >> DIV3_SH equals x / 3 for every x below 2**17
  localparam int DIV3_MUL = 43691;
  localparam int DIV3_SH  = 17;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_KEY_RD,
    ALU_RD_BEST,
    ALU_BEST_KEY
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_EX_KEY,
    S_DN_RD,
    S_DN_CMP,
    S_DN_DEC,
    S_WR_KEY,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/tmhq_req_if.sv
// Request channel of the ternary min-heap queue: valid/ready plus payload.
// Depends on tmhq_pkg.
`default_nettype none

interface tmhq_req_if;
  import tmhq_pkg::*;

  logic valid;
  logic ready;
  req_t req_type;
  key_t value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

`default_nettype wire

// File: rtl/tmhq_rsp_if.sv
// Response channel of the ternary min-heap queue: valid/ready plus payload.
// Depends on tmhq_pkg.
`default_nettype none

interface tmhq_rsp_if;
  import tmhq_pkg::*;

  logic    valid;
  logic    ready;
  key_t    result_value;
  status_t status;
  count_t  count;

  modport source (output valid, result_value, status, count, input ready);
  modport sink   (input valid, result_value, status, count, output ready);
endinterface

`default_nettype wire

// File: rtl/tmhq_ram.sv
// Heap storage: one write port, one read port with registered read data.
// Depends on tmhq_pkg.
`default_nettype none

module tmhq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire tmhq_pkg::key_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output tmhq_pkg::key_t      rdata
);
  import tmhq_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/tmhq_alu.sv
// Shared signed key comparator with operand select.
// Every ordering decision of both sift directions goes through here.
// Depends on tmhq_pkg.
`default_nettype none

module tmhq_alu (
  input  wire tmhq_pkg::alu_op_t op,
  input  wire tmhq_pkg::key_t    key,
  input  wire tmhq_pkg::key_t    rdata,
  input  wire tmhq_pkg::key_t    best,
  output logic                   lt
);
  import tmhq_pkg::*;

  key_t a;
  key_t b;

  always_comb begin
    unique case (op)
      ALU_KEY_RD: begin
        a = key;
        b = rdata;
      end
      ALU_RD_BEST: begin
        a = rdata;
        b = best;
      end
      ALU_BEST_KEY: begin
        a = best;
        b = key;
      end
      default: begin
        a = key;
        b = key;
      end
    endcase
  end

  assign lt = a < b;

endmodule

`default_nettype wire

// File: rtl/ternary_min_heap_queue.sv
// Ternary min-heap priority queue of signed 32-bit keys, one request at a time.
// Insert: the new key sifts up, reading and comparing one parent per level climbed.
// Extract: the last entry sifts down from the root, reading up to three children per level visited.
// Inserting into an empty heap, extracting the last entry and rejected requests skip the sift.
// Rate is set by the single RAM read port and the shared comparator; ready only in idle.
// Synchronous reset empties the queue; the storage itself is never cleared.
`default_nettype none

module ternary_min_heap_queue #(
  parameter int CAPACITY = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tmhq_req_if.sink    req,
  tmhq_rsp_if.source  rsp
);
  import tmhq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int PW = AW + DIV3_SH;

  state_t state;
  state_t state_next;

  logic [CW-1:0] cnt;
  logic [AW-1:0] pos;
  logic [AW-1:0] par;
  logic [XW-1:0] cidx;
  logic [1:0]    kcnt;
  key_t          key;
  key_t          best_val;
  logic [AW-1:0] best_idx;
  key_t          res_val;
  status_t       res_st;

  logic          out_valid;
  key_t          out_val;
  status_t       out_st;
  count_t        out_cnt;

  // memory and compare unit controls
  logic          we;
  logic [AW-1:0] waddr;
  key_t          wdata;
  logic [AW-1:0] raddr;
  key_t          rdata;
  alu_op_t       alu_op;
  logic          lt;

  logic          accept;
  logic [PW-1:0] prod;
  logic [AW-1:0] parent;
  logic [XW-1:0] c1;
  logic [XW-1:0] cnext;
  logic [XW-1:0] cnt_x;
  logic          has_kid;
  logic          more_kid;
  logic          out_free;

  assign accept   = req.valid && req.ready;
  // parent = (pos - 1) / 3 via reciprocal multiply
  assign prod     = PW'(pos - AW'(1)) * PW'(DIV3_MUL);
  assign parent   = prod[PW-1:DIV3_SH];
  assign c1       = XW'({pos, 1'b0}) + XW'(pos) + XW'(1);
  assign cnext    = cidx + XW'(1);
  assign cnt_x    = XW'(cnt);
  assign has_kid  = c1 < cnt_x;
  assign more_kid = (kcnt != 2'd2) && (cnext < cnt_x);
  assign out_free = !out_valid || rsp.ready;

  tmhq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmhq_alu u_alu (
    .op    (alu_op),
    .key   (key),
    .rdata (rdata),
    .best  (best_val),
    .lt    (lt)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_INSERT) begin
            if (cnt >= CW'(CAPACITY)) begin
              state_next = S_FINISH;
            end else if (cnt == '0) begin
              state_next = S_WR_KEY;
            end else begin
              state_next = S_UP_RD;
            end
          end else begin
            state_next = (cnt == '0) ? S_FINISH : S_EX_ROOT;
          end
        end
      end
      S_UP_RD:   state_next = S_UP_CMP;
      S_UP_CMP: begin
        if (lt && par != '0) begin
          state_next = S_UP_RD;
        end else begin
          state_next = S_WR_KEY;
        end
      end
      S_EX_ROOT: state_next = S_EX_LAST;
      S_EX_LAST: state_next = (cnt == '0) ? S_FINISH : S_EX_KEY;
      S_EX_KEY:  state_next = S_DN_RD;
      S_DN_RD:   state_next = has_kid ? S_DN_CMP : S_WR_KEY;
      S_DN_CMP:  state_next = more_kid ? S_DN_CMP : S_DN_DEC;
      S_DN_DEC:  state_next = lt ? S_DN_RD : S_WR_KEY;
      S_WR_KEY:  state_next = S_FINISH;
      S_FINISH:  state_next = out_free ? S_IDLE : S_FINISH;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    we        = 1'b0;
    waddr     = pos;
    wdata     = key;
    raddr     = '0;
    alu_op    = ALU_KEY_RD;
    req.ready = 1'b0;
    unique case (state)
      S_IDLE:    req.ready = 1'b1;
      S_UP_RD:   raddr = parent;
      S_UP_CMP: begin
        alu_op = ALU_KEY_RD;
        we     = lt;
        wdata  = rdata;
      end
      S_EX_ROOT: raddr = '0;
      S_EX_LAST: raddr = AW'(cnt);
      S_DN_RD:   raddr = c1[AW-1:0];
      S_DN_CMP: begin
        alu_op = ALU_RD_BEST;
        raddr  = cnext[AW-1:0];
      end
      S_DN_DEC: begin
        alu_op = ALU_BEST_KEY;
        we     = lt;
        wdata  = best_val;
      end
      S_WR_KEY:  we = 1'b1;
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_IDLE && accept) begin
      if (req.req_type == REQ_INSERT) begin
        if (cnt < CW'(CAPACITY)) begin
          cnt <= cnt + CW'(1);
        end
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_val <= '0;
          pos     <= AW'(cnt);
          key     <= req.value;
          if (req.req_type == REQ_INSERT) begin
            res_st <= (cnt >= CW'(CAPACITY)) ? ST_FULL : ST_INSERTED;
          end else begin
            res_st <= (cnt == '0) ? ST_EMPTY : ST_EXTRACTED;
          end
        end
      end
      S_UP_RD: par <= parent;
      S_UP_CMP: begin
        if (lt) begin
          pos <= par;
        end
      end
      S_EX_LAST: res_val <= rdata;
      S_EX_KEY: begin
        key <= rdata;
        pos <= '0;
      end
      S_DN_RD: begin
        cidx <= c1;
        kcnt <= 2'd0;
      end
      S_DN_CMP: begin
        // first child always taken; later ones only if strictly smaller
        if (kcnt == 2'd0 || lt) begin
          best_val <= rdata;
          best_idx <= cidx[AW-1:0];
        end
        if (more_kid) begin
          cidx <= cnext;
          kcnt <= kcnt + 2'd1;
        end
      end
      S_DN_DEC: begin
        if (lt) begin
          pos <= best_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_val <= res_val;
      out_st  <= res_st;
      out_cnt <= CNT_W'(cnt);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_val;
  assign rsp.status       = out_st;
  assign rsp.count        = out_cnt;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_moves_on_request: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cnt != $past(cnt)) |-> $past(accept))
    else $error("entry count changed without a request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("ready while a request is in flight");

  a_sift_up_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_RD) |-> (pos != '0))
    else $error("sift-up step issued at the root");

endmodule

`default_nettype wire

// File: dv/tmhq_checker.sv
// Scoreboard for the ternary min-heap queue: watches both channels, keeps its own heap,
// predicts each response and compares it field by field.
// Depends on tmhq_pkg, tmhq_req_if and tmhq_rsp_if.
`default_nettype none

module tmhq_checker
  import tmhq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  tmhq_req_if       req,
  tmhq_rsp_if       rsp,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    key_t    value;
    status_t status;
    count_t  count;
  } heap_rsp_t;

  key_t        heap_keys [CAPACITY];
  int unsigned heap_size;
  heap_rsp_t   awaited_rsps [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    heap_size  = 0;
  end

  // Applies one request to the local heap and returns the response it should produce.
  function automatic heap_rsp_t apply_to_heap(req_t op, key_t key);
    heap_rsp_t   r;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned c;
    key_t        tmp;
    bit          found;
    bit          moving;
    r.value = '0;
    if (op == REQ_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_keys[heap_size] = key;
        pos = heap_size;
        heap_size++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 3;
          if (heap_keys[pos] < heap_keys[up]) begin
            tmp             = heap_keys[pos];
            heap_keys[pos]  = heap_keys[up];
            heap_keys[up]   = tmp;
            pos             = up;
          end else begin
            moving = 1'b0;
          end
        end
        r.status = ST_INSERTED;
      end
    end else if (heap_size == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = heap_keys[0];
      heap_size--;
      heap_keys[0] = heap_keys[heap_size];
      pos = 0;
      moving = 1'b1;
      while (moving) begin
        found = 1'b0;
        best  = 0;
        // smallest child, lowest index wins a tie
        for (int k = 1; k <= 3; k++) begin
          c = pos * 3 + k;
          if (c < heap_size && (!found || heap_keys[c] < heap_keys[best])) begin
            best  = c;
            found = 1'b1;
          end
        end
        if (found && heap_keys[best] < heap_keys[pos]) begin
          tmp             = heap_keys[pos];
          heap_keys[pos]  = heap_keys[best];
          heap_keys[best] = tmp;
          pos             = best;
        end else begin
          moving = 1'b0;
        end
      end
      r.status = ST_EXTRACTED;
    end
    r.count = count_t'(heap_size);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_rsp_t want;
    if (rst) begin
      heap_size = 0;
      awaited_rsps.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t checker: response with no request pending: value=%0d status=%0d count=%0d",
                     $realtime, rsp.result_value, rsp.status, rsp.count);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.result_value !== want.value || rsp.status !== want.status ||
              rsp.count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t checker: mismatch exp value=%0d status=%0d count=%0d got value=%0d status=%0d count=%0d",
                       $realtime, want.value, want.status, want.count,
                       rsp.result_value, rsp.status, rsp.count);
          end
        end
      end
      if (req.valid && req.ready)
        awaited_rsps.push_back(apply_to_heap(req.req_type, req.value));
    end
    pending <= awaited_rsps.size();
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench top for the ternary min-heap queue: clock, reset, request stimulus with bursts,
// response back-pressure, watchdog and verdict. Depends on tmhq_pkg, both channel
// interfaces, the RTL top and tmhq_checker.
`default_nettype none

module tb_top;
  import tmhq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_CAP   = 1024;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 60;

  typedef enum int {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_EVERY3
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   rsp_seen;
  int   idle_cycles;
  int   burst_left;

  tmhq_req_if req_ch ();
  tmhq_rsp_if rsp_ch ();

  ternary_min_heap_queue #(.CAPACITY(HEAP_CAP)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  tmhq_checker #(.CAPACITY(HEAP_CAP)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      rsp_seen    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        rsp_seen <= rsp_seen + 1;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // response side: stall pattern re-picked at random periodically, plus one long hold
  initial begin
    rx_mode_t mode;
    int       cyc;
    int       hold;
    bit       hold_done;
    mode      = RX_OPEN;
    cyc       = 0;
    hold      = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0)
        mode = rx_mode_t'($urandom_range(0, 3));
      cyc++;
      if (!hold_done && rsp_seen >= 60) begin
        hold_done = 1'b1;
        hold      = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   rsp_ch.ready <= 1'b1;
          RX_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_ch.ready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  function automatic key_t pick_key();
    case ($urandom_range(0, 5))
      0:       return key_t'($urandom_range(0, 6)) - key_t'(3);
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2:       return key_t'($urandom_range(0, 15)) - key_t'(8);
      default: return key_t'($urandom);
    endcase
  endfunction

  // Offers one request; bursts of random length are separated by random gaps.
  task automatic send_req(req_t op, key_t key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= req_t'($urandom_range(0, 1));
        req_ch.value    <= key_t'($urandom);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.value    <= key;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic mixed_reqs(int n);
    int pct;
    pct = 50;
    for (int i = 0; i < n; i++) begin
      // swing the insert ratio so the fill level wanders up and down
      if (i % 50 == 0)
        pct = ($urandom_range(0, 1)) ? 75 : 35;
      if ($urandom_range(0, 99) < pct)
        send_req(REQ_INSERT, pick_key());
      else
        send_req(REQ_EXTRACT, key_t'($urandom));
    end
  endtask

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.value    <= '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty extract, extremes, equal keys, drain past empty
    send_req(REQ_EXTRACT, 32'sh1234_5678);
    send_req(REQ_INSERT, 32'sd0);
    send_req(REQ_INSERT, 32'sh7FFF_FFFF);
    send_req(REQ_INSERT, 32'sh8000_0000);
    send_req(REQ_INSERT, -32'sd1);
    send_req(REQ_INSERT, 32'sd1);
    send_req(REQ_INSERT, 32'sd5);
    send_req(REQ_INSERT, 32'sd5);
    send_req(REQ_INSERT, 32'sd5);
    send_req(REQ_INSERT, 32'sh8000_0000);
    repeat (10) send_req(REQ_EXTRACT, key_t'($urandom));

    mixed_reqs(50);

    // fill past capacity so inserts get rejected, then mix on a deep heap
    repeat (HEAP_CAP + 3) send_req(REQ_INSERT, pick_key());

    mixed_reqs(30);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
